/* design/mss_pkg.sv */
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, constants and the segment font for the seven-segment scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

  // Default number of display digits.
  localparam int MAX_DIGITS_DEF = 8;

  // Digit count field, wide enough for any digit count in range.
  localparam int DIGIT_CNT_W = 4;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_PIN_POLARITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_IN_USE = 1'd1;

  // Item opcodes.
  localparam logic [1:0] OP_WRITE_NUM = 2'd0;
  localparam logic [1:0] OP_SET_DOT   = 2'd1;
  localparam logic [1:0] OP_TICK      = 2'd2;

  // Digit code store: codes 0..15 are hex digits, anything above is blank.
  localparam logic [4:0] CODE_BLANK = 5'd31;

  // Reciprocal of ten, scaled by 2^35.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;
  localparam int          RECIP_SH  = 35;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] value;
    logic [2:0]  digit_index;
    logic        dot_on;
  } mss_in_t;

  typedef struct packed {
    logic [7:0] segment_pins;
    logic [2:0] active_digit;
  } mss_out_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic                   load;     // latch value, clear dots
    logic                   step;     // convert one digit
    logic [DIGIT_CNT_W-1:0] step_idx; // digit being converted
    logic                   set_dot;
    logic                   tick;
  } mss_cmd_t;

  // Hex font, A in bit 0 through G in bit 6; blank codes give no segments.
  function automatic logic [7:0] seg_font(input logic [4:0] code);
    logic [7:0] seg;
    seg = 8'h00;
    if (!code[4]) begin
      unique case (code[3:0])
        4'h0: seg = 8'h3F;
        4'h1: seg = 8'h06;
        4'h2: seg = 8'h5B;
        4'h3: seg = 8'h4F;
        4'h4: seg = 8'h66;
        4'h5: seg = 8'h6D;
        4'h6: seg = 8'h7D;
        4'h7: seg = 8'h07;
        4'h8: seg = 8'h7F;
        4'h9: seg = 8'h6F;
        4'hA: seg = 8'h77;
        4'hB: seg = 8'h7C;
        4'hC: seg = 8'h39;
        4'hD: seg = 8'h5E;
        4'hE: seg = 8'h79;
        4'hF: seg = 8'h71;
        default: seg = 8'h00;
      endcase
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

/* design/mss_ctrl.sv */
// ----------------------------------------------------------------------------
// mss_ctrl
// Item sequencer: decodes the opcode, steps number conversion one digit per
// cycle and raises the result strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_ctrl #(
  parameter int MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [1:0]       op,
  output logic                  busy,
  output logic                  out_strobe,
  output mss_pkg::mss_cmd_t     cmd
);
  import mss_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_DIGITS - 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CONV = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic             strobe_r, strobe_nxt;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    strobe_nxt   = 1'b0;
    cmd          = '0;
    cmd.step_idx = DIGIT_CNT_W'(cnt_r);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          if (op == OP_WRITE_NUM) begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_CONV;
          end else begin
            // set dot, tick and unknown ops finish at once
            cmd.set_dot = (op == OP_SET_DOT);
            cmd.tick    = (op == OP_TICK);
            strobe_nxt  = 1'b1;
          end
        end
      end
      S_CONV: begin
        cmd.step = 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
        end else begin
          cnt_nxt = IDX_W'(cnt_r + 1'b1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = strobe_r;

endmodule

`default_nettype wire

/* design/mss_datapath.sv */
// ----------------------------------------------------------------------------
// mss_datapath
// Config registers, digit code and dot store, divide-by-ten digit peeler and
// scan position / segment driver.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_datapath #(
  parameter int MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire mss_pkg::mss_cmd_t                   cmd,
  input  wire mss_pkg::mss_in_t                    in_word,
  input  wire logic                                cfg_we,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  output mss_pkg::mss_out_t                        out_word
);
  import mss_pkg::*;

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [DIGIT_CNT_W-1:0] MAX_CNT = DIGIT_CNT_W'(MAX_DIGITS);

  logic                          ca_r, ca_nxt;
  logic [DIGIT_CNT_W-1:0]        diu_r, diu_nxt;
  logic [MAX_DIGITS-1:0][4:0]    code_r, code_nxt;
  logic [MAX_DIGITS-1:0]         dot_r, dot_nxt;
  logic [31:0]                   value_r, value_nxt;
  logic [2:0]                    active_r, active_nxt;
  logic [7:0]                    seg_r, seg_nxt;

  logic [DIGIT_CNT_W-1:0]        n_use;
  logic [63:0]                   prod;
  logic [31:0]                   quot;
  logic [31:0]                   quot_x10;
  logic [31:0]                   diff;
  logic [DIGIT_CNT_W-1:0]        next_raw;
  logic [DIGIT_CNT_W-1:0]        next_pos;
  logic [IDX_W-1:0]              next_sel;
  logic [IDX_W-1:0]              step_sel;

  // digit count saturated into 1..MAX_DIGITS
  always_comb begin
    if (diu_r == '0) begin
      n_use = DIGIT_CNT_W'(1);
    end else if (diu_r > MAX_CNT) begin
      n_use = MAX_CNT;
    end else begin
      n_use = diu_r;
    end
  end

  // v / 10 by reciprocal multiply; remainder by shift-add and subtract
  assign prod     = {32'b0, value_r} * {32'b0, RECIP_TEN};
  assign quot     = 32'(prod[63:RECIP_SH]);
  assign quot_x10 = {quot[28:0], 3'b000} + {quot[30:0], 1'b0};
  assign diff     = value_r - quot_x10;

  assign next_raw = DIGIT_CNT_W'(active_r) + DIGIT_CNT_W'(1);
  assign next_pos = (next_raw >= n_use) ? '0 : next_raw;
  assign next_sel = next_pos[IDX_W-1:0];
  assign step_sel = cmd.step_idx[IDX_W-1:0];

  always_comb begin
    ca_nxt     = ca_r;
    diu_nxt    = diu_r;
    code_nxt   = code_r;
    dot_nxt    = dot_r;
    value_nxt  = value_r;
    active_nxt = active_r;
    seg_nxt    = seg_r;

    if (cfg_we) begin
      unique case (cfg_index)
        REG_PIN_POLARITY:  ca_nxt  = cfg_wdata[0];
        REG_DIGITS_IN_USE: diu_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (cmd.load) begin
      value_nxt = in_word.value;
      dot_nxt   = '0;
    end

    if (cmd.step) begin
      // digit 0 always shows, so a zero value gives a single '0'
      if ((cmd.step_idx < n_use) && ((value_r != '0) || (cmd.step_idx == '0))) begin
        code_nxt[step_sel] = {1'b0, diff[3:0]};
        value_nxt          = quot;
      end else begin
        code_nxt[step_sel] = CODE_BLANK;
      end
    end

    if (cmd.set_dot && (DIGIT_CNT_W'(in_word.digit_index) < n_use)) begin
      dot_nxt[IDX_W'(in_word.digit_index)] = in_word.dot_on;
    end

    if (cmd.tick) begin
      active_nxt = next_pos[2:0];
      seg_nxt    = seg_font(code_r[next_sel]) | {dot_r[next_sel], 7'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ca_r     <= 1'b0;
      diu_r    <= DIGIT_CNT_W'(8);
      code_r   <= {MAX_DIGITS{CODE_BLANK}};
      dot_r    <= '0;
      active_r <= '0;
      seg_r    <= '0;
    end else begin
      ca_r     <= ca_nxt;
      diu_r    <= diu_nxt;
      code_r   <= code_nxt;
      dot_r    <= dot_nxt;
      active_r <= active_nxt;
      seg_r    <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  // polarity applied at the pins
  assign out_word.segment_pins = seg_r ^ {8{ca_r}};
  assign out_word.active_digit = active_r;

endmodule

`default_nettype wire

/* design/multiplexed_seven_segment_scanner.sv */
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner
// Multiplexed seven-segment display scanner with decimal number loading.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_word and pulse start; the word is taken on a clock edge
//   with start high and busy low. Ops: write number, set dot, scan tick.
//   Output: every word yields one result (segment pins and active digit) on
//   out_word, valid for the single cycle out_strobe is high. The receiver
//   cannot stall; the result must be captured in that cycle.
//   Config: cfg_we with cfg_index/cfg_wdata writes the pin polarity (index 0)
//   or digits_in_use (index 1) at once; write only while the block is idle.
// Timing and throughput:
//   Set dot, scan tick and unknown ops: result strobed in the cycle after
//   acceptance, busy stays low, so one word per cycle.
//   Write number: the divide-by-ten step peels one digit per cycle over all
//   MAX_DIGITS positions while busy; the result is strobed in the cycle after
//   the last step, and the next word is accepted in that same cycle.
// Reset (synchronous, rst_n low): all digits blank, dots clear, digit 0
//   active, segments off, common cathode, eight digits in use.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_scanner #(
  parameter int MAX_DIGITS = mss_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire mss_pkg::mss_in_t                in_word,
  output logic                                 out_strobe,
  output mss_pkg::mss_out_t                    out_word,
  input  wire logic                            cfg_we,
  input  wire logic [mss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mss_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mss_pkg::*;

  mss_cmd_t cmd;

  mss_ctrl #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .op         (in_word.op),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  mss_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_word  (out_word)
  );

`ifndef NO_ASSERTIONS
  // no result while a conversion is running
  a_no_strobe_busy : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe during conversion");

  // set dot, tick and unknown ops answer on the next cycle
  a_quick_result : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.op != OP_WRITE_NUM)) |=> (out_strobe && !busy))
    else $error("missing result for single-cycle word");

  // a number write always starts a conversion
  a_write_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_word.op == OP_WRITE_NUM)) |=> (busy && !out_strobe))
    else $error("number write did not start conversion");

  // busy only ends with the conversion result
  a_busy_end : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("conversion ended without result");
`endif

endmodule

`default_nettype wire
